// ===== sv/rtphp_pkg.sv =====
`timescale 1ns / 1ps
// rtphp_pkg: shared constants for the RTP header parser.
// Used by rtp_header_parser_unit and rtphp_checker; no dependencies.
package rtphp_pkg;

    // fixed RTP header layout
    localparam int unsigned MIN_HEADER_BYTES = 12;
    localparam logic [1:0]  RTP_VERSION      = 2'd2;

    // one-byte-form extension elements
    localparam logic [3:0]  STOP_ELEMENT_ID       = 4'hF;
    localparam int unsigned CAPTURE_ELEMENT_BYTES = 8;
    localparam logic [3:0]  CAPTURE_LEN_CODE      = 4'(CAPTURE_ELEMENT_BYTES - 1);

    // size limit default
    localparam int unsigned MAX_DATAGRAM_BYTES_DEF = 65535;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_EXT_PROFILE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_ID  = 1'b1;

    localparam logic [15:0] EXT_PROFILE_RST = 16'hBEDE;
    localparam logic [3:0]  CAPTURE_ID_RST  = 4'd1;

endpackage

// ===== sv/rtp_header_parser_unit.sv =====
`timescale 1ns / 1ps
// rtp_header_parser_unit: byte-serial RTP header parser with capture time extraction.
// Depends on rtphp_pkg.
//
// Usage:
//   Byte channel: data_byte/last_byte with byte_valid/byte_stall, one datagram
//   word per byte, last_byte set on the final byte. Result channel: one word
//   per datagram (valid_res ... payload_length) with res_valid/res_stall.
//   Config: cfg_we/cfg_index/cfg_data, written only while the parser is idle (by the
//   user; the block does not enforce it). Throughput: one byte per cycle, sustained,
//   back to back across datagrams, unless a final byte waits behind a stalled result.
// Result path: the final byte passes the input register, then the result
//   register; the per-byte parse and the end-of-datagram checks sit between them.
// Stall: a result waits in the output register while res_stall is high.
//   Non-final bytes keep flowing; byte_stall rises only when a final byte
//   is held in the input register behind a result that has not been taken.
// Reset: clears the parse state, both pipeline valids and restores the
//   config registers (profile 0xBEDE, element id 1).
module rtp_header_parser_unit #(
    parameter int unsigned MAX_DATAGRAM_BYTES = rtphp_pkg::MAX_DATAGRAM_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rtphp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rtphp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             byte_valid,
    output logic                             byte_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic                             valid_res,
    output logic [15:0]                      sequence_number,
    output logic [31:0]                      rtp_timestamp,
    output logic [31:0]                      source_id,
    output logic [6:0]                       media_type,
    output logic                             marker,
    output logic [63:0]                      capture_time,
    output logic [15:0]                      media_offset,
    output logic [15:0]                      payload_length
);
    import rtphp_pkg::*;

    // config
    logic [15:0] ext_profile_reg;
    logic [3:0]  capture_id_reg;

    // input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // parse state
    logic [15:0] byte_count_reg, byte_count_next;
    logic        too_long_reg, too_long_next;
    logic [7:0]  fhb_reg, fhb_next;
    logic [7:0]  shb_reg, shb_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] src_reg, src_next;
    logic [15:0] profile_reg, profile_next;
    logic [15:0] ext_words_reg, ext_words_next;
    logic [18:0] pay_start_reg, pay_start_next;
    logic [3:0]  elem_left_reg, elem_left_next;
    logic        elem_match_reg, elem_match_next;
    logic        elem_active_reg, elem_active_next;
    logic        walk_stop_reg, walk_stop_next;
    logic [63:0] cap_shift_reg, cap_shift_next;
    logic [63:0] cap_hold_reg, cap_hold_next;
    logic        fault_reg, fault_next;

    // result register
    logic        res_valid_reg;
    logic        valid_res_reg;
    logic [15:0] seq_out_reg;
    logic [31:0] ts_out_reg;
    logic [31:0] src_out_reg;
    logic [6:0]  pt_out_reg;
    logic        marker_out_reg;
    logic [63:0] cap_out_reg;
    logic [15:0] off_out_reg;
    logic [15:0] len_out_reg;

    logic        s1_adv;
    logic        byte_accept;
    logic        res_take;

    logic [6:0]  ext_start;
    logic [15:0] idx;
    logic [7:0]  b;

    logic        fin_ok;
    logic [18:0] fin_off;
    logic [18:0] fin_len;

    assign res_take    = res_valid_reg && !res_stall;
    assign s1_adv      = s1_valid_reg && (!s1_last_reg || !res_valid_reg || !res_stall);
    assign byte_stall  = s1_valid_reg && !s1_adv;
    assign byte_accept = byte_valid && !byte_stall;

    assign idx       = byte_count_reg;
    assign b         = s1_byte_reg;
    assign ext_start = 7'(MIN_HEADER_BYTES) + {1'b0, fhb_reg[3:0], 2'b00};

    // per-byte header/extension parse
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        too_long_next    = too_long_reg;
        fhb_next         = fhb_reg;
        shb_next         = shb_reg;
        seq_next         = seq_reg;
        ts_next          = ts_reg;
        src_next         = src_reg;
        profile_next     = profile_reg;
        ext_words_next   = ext_words_reg;
        pay_start_next   = pay_start_reg;
        elem_left_next   = elem_left_reg;
        elem_match_next  = elem_match_reg;
        elem_active_next = elem_active_reg;
        walk_stop_next   = walk_stop_reg;
        cap_shift_next   = cap_shift_reg;
        cap_hold_next    = cap_hold_reg;
        fault_next       = fault_reg;

        if (too_long_reg || byte_count_reg >= 16'(MAX_DATAGRAM_BYTES))
        begin
            too_long_next = 1'b1;
        end
        else
        begin
            byte_count_next = byte_count_reg + 16'd1;
            if (idx == 16'd0)
            begin
                fhb_next = b;
            end
            else if (idx == 16'd1)
            begin
                shb_next = b;
            end
            else if (idx < 16'd4)
            begin
                seq_next = {seq_reg[7:0], b};
            end
            else if (idx < 16'd8)
            begin
                ts_next = {ts_reg[23:0], b};
            end
            else if (idx < 16'(MIN_HEADER_BYTES))
            begin
                src_next = {src_reg[23:0], b};
            end
            else if (!fhb_reg[4] || idx < {9'd0, ext_start})
            begin
                // CSRC list or payload without extension: nothing to keep
            end
            else if (idx < {9'd0, ext_start} + 16'd2)
            begin
                profile_next = {profile_reg[7:0], b};
            end
            else if (idx < {9'd0, ext_start} + 16'd4)
            begin
                ext_words_next = {ext_words_reg[7:0], b};
                if (idx == {9'd0, ext_start} + 16'd3)
                    pay_start_next = {12'd0, ext_start} + 19'd4 + {1'b0, ext_words_next, 2'b00};
            end
            else if ({3'd0, idx} < pay_start_reg && profile_reg == ext_profile_reg
                     && !walk_stop_reg)
            begin
                if (elem_active_reg)
                begin
                    cap_shift_next = {cap_shift_reg[55:0], b};
                    if (elem_left_reg == 4'd0)
                    begin
                        elem_active_next = 1'b0;
                        if (elem_match_reg)
                            cap_hold_next = cap_shift_next;
                    end
                    else
                    begin
                        elem_left_next = elem_left_reg - 4'd1;
                    end
                end
                else if (b == 8'd0)
                begin
                    // padding byte between elements
                end
                else if (b[7:4] == STOP_ELEMENT_ID)
                begin
                    walk_stop_next = 1'b1;
                end
                else if ({3'd0, idx} + {15'd0, b[3:0]} + 19'd2 > pay_start_reg)
                begin
                    // element runs past the extension
                    fault_next     = 1'b1;
                    walk_stop_next = 1'b1;
                end
                else
                begin
                    elem_active_next = 1'b1;
                    elem_left_next   = b[3:0];
                    elem_match_next  = (b[7:4] == capture_id_reg)
                                       && (b[3:0] == CAPTURE_LEN_CODE);
                end
            end
        end
    end

    // end-of-datagram checks, on the state after the final byte
    always_comb
    begin
        logic [18:0] total;
        logic [18:0] off_base;
        logic [18:0] end_v;
        logic        ok;

        total    = {3'd0, byte_count_next};
        off_base = 19'(MIN_HEADER_BYTES) + {13'd0, fhb_next[3:0], 2'b00};
        ok       = !too_long_next && total >= 19'(MIN_HEADER_BYTES)
                   && fhb_next[7:6] == RTP_VERSION && !fault_next;
        fin_off  = off_base;
        end_v    = total;

        if (ok && off_base > total)
            ok = 1'b0;
        if (ok && fhb_next[4])
        begin
            if (off_base + 19'd4 > total)
            begin
                ok = 1'b0;
            end
            else
            begin
                fin_off = pay_start_next;
                if (fin_off > total)
                    ok = 1'b0;
            end
        end
        // padding count is the final byte itself
        if (ok && fhb_next[5])
        begin
            if (b == 8'd0 || {11'd0, b} > end_v - fin_off)
                ok = 1'b0;
            else
                end_v = end_v - {11'd0, b};
        end
        if (ok && fin_off >= end_v)
            ok = 1'b0;

        fin_ok  = ok;
        fin_len = end_v - fin_off;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_profile_reg <= EXT_PROFILE_RST;
            capture_id_reg  <= CAPTURE_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EXT_PROFILE: ext_profile_reg <= cfg_data;
                REG_CAPTURE_ID:  capture_id_reg  <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            too_long_reg    <= 1'b0;
            fhb_reg         <= '0;
            shb_reg         <= '0;
            seq_reg         <= '0;
            ts_reg          <= '0;
            src_reg         <= '0;
            profile_reg     <= '0;
            ext_words_reg   <= '0;
            pay_start_reg   <= '0;
            elem_left_reg   <= '0;
            elem_match_reg  <= 1'b0;
            elem_active_reg <= 1'b0;
            walk_stop_reg   <= 1'b0;
            cap_shift_reg   <= '0;
            cap_hold_reg    <= '0;
            fault_reg       <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                // datagram done: back to a clean slate
                byte_count_reg  <= '0;
                too_long_reg    <= 1'b0;
                fhb_reg         <= '0;
                shb_reg         <= '0;
                seq_reg         <= '0;
                ts_reg          <= '0;
                src_reg         <= '0;
                profile_reg     <= '0;
                ext_words_reg   <= '0;
                pay_start_reg   <= '0;
                elem_left_reg   <= '0;
                elem_match_reg  <= 1'b0;
                elem_active_reg <= 1'b0;
                walk_stop_reg   <= 1'b0;
                cap_shift_reg   <= '0;
                cap_hold_reg    <= '0;
                fault_reg       <= 1'b0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                too_long_reg    <= too_long_next;
                fhb_reg         <= fhb_next;
                shb_reg         <= shb_next;
                seq_reg         <= seq_next;
                ts_reg          <= ts_next;
                src_reg         <= src_next;
                profile_reg     <= profile_next;
                ext_words_reg   <= ext_words_next;
                pay_start_reg   <= pay_start_next;
                elem_left_reg   <= elem_left_next;
                elem_match_reg  <= elem_match_next;
                elem_active_reg <= elem_active_next;
                walk_stop_reg   <= walk_stop_next;
                cap_shift_reg   <= cap_shift_next;
                cap_hold_reg    <= cap_hold_next;
                fault_reg       <= fault_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_take)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            valid_res_reg  <= fin_ok;
            seq_out_reg    <= fin_ok ? seq_next : '0;
            ts_out_reg     <= fin_ok ? ts_next : '0;
            src_out_reg    <= fin_ok ? src_next : '0;
            pt_out_reg     <= fin_ok ? shb_next[6:0] : '0;
            marker_out_reg <= fin_ok ? shb_next[7] : 1'b0;
            cap_out_reg    <= fin_ok ? cap_hold_next : '0;
            off_out_reg    <= fin_ok ? fin_off[15:0] : '0;
            len_out_reg    <= fin_ok ? fin_len[15:0] : '0;
        end
    end

    assign res_valid       = res_valid_reg;
    assign valid_res       = valid_res_reg;
    assign sequence_number = seq_out_reg;
    assign rtp_timestamp   = ts_out_reg;
    assign source_id       = src_out_reg;
    assign media_type      = pt_out_reg;
    assign marker          = marker_out_reg;
    assign capture_time    = cap_out_reg;
    assign media_offset    = off_out_reg;
    assign payload_length  = len_out_reg;

endmodule

// ===== sv/rtphp_checker.sv =====
`timescale 1ns / 1ps
// rtphp_checker: port-level assertions for rtp_header_parser_unit, bound to it.
// Depends on rtphp_pkg.
module rtphp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic        valid_res,
    input logic [15:0] sequence_number,
    input logic [31:0] rtp_timestamp,
    input logic [31:0] source_id,
    input logic [6:0]  media_type,
    input logic        marker,
    input logic [63:0] capture_time,
    input logic [15:0] media_offset,
    input logic [15:0] payload_length
);
    import rtphp_pkg::*;

    // a held result word stays up
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result word dropped while stalled");

    // the byte side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> res_valid && res_stall)
        else $error("byte stall without a stalled result");

    // rejected datagrams carry all-zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !valid_res |-> sequence_number == '0 && rtp_timestamp == '0
            && source_id == '0 && media_type == '0 && !marker
            && capture_time == '0 && media_offset == '0 && payload_length == '0)
        else $error("rejected result with nonzero fields");

    // accepted datagrams: word-aligned offset past the fixed header, nonempty payload
    a_accept_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && valid_res |-> media_offset[1:0] == 2'b00
            && media_offset >= 16'(MIN_HEADER_BYTES) && payload_length != '0)
        else $error("accepted result with bad offset or length");

endmodule

bind rtp_header_parser_unit rtphp_checker u_rtphp_checker (.*);
